### rtl/plom_pkg.sv
// package for the piecewise-linear opacity map unit
// field widths, register indexes and the divider status type
// no dependencies
package plom_pkg;

  localparam int POS_W     = 32;
  localparam int OPAC_W    = 16;
  localparam int PT_W      = 48;
  localparam int NUM_W     = 3;
  localparam int CFG_IDX_W = 3;
  localparam int SPAN_W    = 32;
  localparam int PROD_W    = SPAN_W + OPAC_W;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_POINTS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_0    = 3'd1;

  localparam logic [NUM_W-1:0] NUM_POINTS_RST = 3'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

### rtl/plom_cfg_regs.sv
// control point register file with one read port
// depends on plom_pkg
module plom_cfg_regs
  import plom_pkg::*;
#(
  parameter int MAX_POINTS = 7,
  parameter int IDX_W      = 3
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [PT_W-1:0]         cfg_wdata,
  input  logic [IDX_W-1:0]        rd_idx,
  output logic signed [POS_W-1:0] rd_pos,
  output logic [OPAC_W-1:0]       rd_opac,
  output logic [IDX_W-1:0]        last_idx
);

  logic [NUM_W-1:0]        num_points_r;
  logic signed [POS_W-1:0] pos_r  [MAX_POINTS];
  logic [OPAC_W-1:0]       opac_r [MAX_POINTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_points_r <= NUM_POINTS_RST;
    end else if (cfg_we && cfg_index == REG_NUM_POINTS) begin
      num_points_r <= cfg_wdata[NUM_W-1:0];
    end
  end

  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_pt
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pos_r[k]  <= '0;
        opac_r[k] <= '0;
      end else if (cfg_we && cfg_index == CFG_IDX_W'(REG_POINT_0 + k)) begin
        pos_r[k]  <= cfg_wdata[PT_W-1:OPAC_W];
        opac_r[k] <= cfg_wdata[OPAC_W-1:0];
      end
    end
  end

  // zero points count as one, too many clamp to the storage depth
  always_comb begin
    if (num_points_r == '0) begin
      last_idx = '0;
    end else if (num_points_r > NUM_W'(MAX_POINTS)) begin
      last_idx = IDX_W'(MAX_POINTS - 1);
    end else begin
      last_idx = IDX_W'(num_points_r - 3'd1);
    end
  end

  always_comb begin
    if (32'(rd_idx) < MAX_POINTS) begin
      rd_pos  = pos_r[rd_idx];
      rd_opac = opac_r[rd_idx];
    end else begin
      rd_pos  = '0;
      rd_opac = '0;
    end
  end

endmodule

### rtl/plom_div.sv
// restoring serial divider, one quotient bit per cycle
// quotient is known to fit OPAC_W bits; depends on plom_pkg
module plom_div
  import plom_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] num,
  input  logic [SPAN_W-1:0] den,
  output div_sts_t          sts,
  output logic [OPAC_W-1:0] quot
);

  localparam int CNT_W = $clog2(OPAC_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SPAN_W-1:0] rem_r, rem_nxt;
  logic [SPAN_W-1:0] den_r, den_nxt;
  logic [OPAC_W-1:0] qb_r, qb_nxt;
  logic [SPAN_W:0]   sh;
  logic [SPAN_W:0]   diff;

  always_comb begin
    sh       = {rem_r, qb_r[OPAC_W-1]};
    diff     = sh - {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    qb_nxt   = qb_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = num[PROD_W-1:OPAC_W];
      qb_nxt   = num[OPAC_W-1:0];
      den_nxt  = den;
    end else if (busy_r) begin
      if (!diff[SPAN_W]) begin
        rem_nxt = diff[SPAN_W-1:0];
        qb_nxt  = {qb_r[OPAC_W-2:0], 1'b1};
      end else begin
        rem_nxt = sh[SPAN_W-1:0];
        qb_nxt  = {qb_r[OPAC_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(OPAC_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    qb_r  <= qb_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quot     = qb_r;

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !start |-> rem_r < den_r)
    else $error("divider remainder not below divisor");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r)
    else $error("divider not busy after start");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while busy");

endmodule

### rtl/piecewise_linear_opacity_map_unit.sv
// top level of the piecewise-linear opacity map unit
// depends on plom_pkg, plom_cfg_regs and plom_div
//
// maps a signed position to an opacity through up to MAX_POINTS control points.
// input stream: in_tdata carries the position, in_tuser the valid flag and
// in_tlast the last-entry mark. output stream: out_tdata carries the opacity,
// out_tlast copies the last-entry mark. one result per input transaction.
// control points and their count are to be written over the cfg port while
// idle by the user; the unit does not enforce this. one item at a time:
// in_tready is high only while the sequencer is idle. an invalid position
// goes straight to the final step, a clamped one after the end checks, and
// an interpolated one after the point walk, multiply and, for a positive span,
// divide. the point walk reads one point per cycle through the single compare
// unit, and the 16-step serial divider produces one quotient bit per cycle.
// the result waits in an output register; a new transaction is taken while it
// waits, and a stalled receiver holds the sequencer at its final step only
// when a second result is ready before the first is taken.
// reset clears the sequencer and output valid and restores the registers to
// two points, all at position and opacity zero.
module piecewise_linear_opacity_map_unit
  import plom_pkg::*;
#(
  parameter int MAX_POINTS = 7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [POS_W-1:0]     in_tdata,   // [31:0] position
  input  logic                 in_tuser,   // [0] position_valid
  input  logic                 in_tlast,   // last_entry
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OPAC_W-1:0]    out_tdata,  // [15:0] opacity
  output logic                 out_tlast,  // last_out
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PT_W-1:0]      cfg_wdata
);

  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_CHK_LO = 9'b000000010,
    ST_CHK_HI = 9'b000000100,
    ST_SRCH   = 9'b000001000,
    ST_LOWER  = 9'b000010000,
    ST_MULT   = 9'b000100000,
    ST_DIVGO  = 9'b001000000,
    ST_DIV    = 9'b010000000,
    ST_FIN    = 9'b100000000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [IDX_W-1:0]        k_r, k_nxt;
  logic signed [POS_W-1:0] p_r, p_nxt;
  logic                    last_r, last_nxt;
  logic signed [POS_W-1:0] x1_r, x1_nxt;
  logic [OPAC_W-1:0]       o1_r, o1_nxt;
  logic [OPAC_W-1:0]       o0_r, o0_nxt;
  logic [SPAN_W-1:0]       t_r, t_nxt;
  logic signed [SPAN_W:0]  span_r, span_nxt;
  logic                    neg_r, neg_nxt;
  logic [OPAC_W-1:0]       mag_r, mag_nxt;
  logic [PROD_W-1:0]       prod_r, prod_nxt;
  logic [OPAC_W-1:0]       res_r, res_nxt;
  logic                    out_tvalid_r, out_tvalid_nxt;
  logic [OPAC_W-1:0]       out_opac_r, out_opac_nxt;
  logic                    out_last_r, out_last_nxt;

  logic [IDX_W-1:0]        rd_idx;
  logic signed [POS_W-1:0] rd_pos;
  logic [OPAC_W-1:0]       rd_opac;
  logic [IDX_W-1:0]        last_idx;
  logic [POS_W:0]          cmp_diff;
  logic                    cmp_lt;
  logic                    cmp_eq;
  logic [OPAC_W:0]         d_opac;
  logic                    div_start;
  div_sts_t                div_sts;
  logic [OPAC_W-1:0]       quot;
  logic                    span_pos;
  logic                    out_free;

  plom_cfg_regs #(
    .MAX_POINTS (MAX_POINTS),
    .IDX_W      (IDX_W)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .rd_idx    (rd_idx),
    .rd_pos    (rd_pos),
    .rd_opac   (rd_opac),
    .last_idx  (last_idx)
  );

  plom_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (prod_r),
    .den   (span_r[SPAN_W-1:0]),
    .sts   (div_sts),
    .quot  (quot)
  );

  // shared compare unit: position minus the point read this cycle
  assign cmp_diff = {p_r[POS_W-1], p_r} - {rd_pos[POS_W-1], rd_pos};
  assign cmp_lt   = cmp_diff[POS_W];
  assign cmp_eq   = (cmp_diff == '0);
  assign d_opac   = {1'b0, o1_r} - {1'b0, rd_opac};
  assign span_pos = !span_r[SPAN_W] && (span_r != '0);
  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    unique case (state_r)
      ST_CHK_LO: rd_idx = '0;
      ST_CHK_HI: rd_idx = last_idx;
      default:   rd_idx = k_r;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    k_nxt          = k_r;
    p_nxt          = p_r;
    last_nxt       = last_r;
    x1_nxt         = x1_r;
    o1_nxt         = o1_r;
    o0_nxt         = o0_r;
    t_nxt          = t_r;
    span_nxt       = span_r;
    neg_nxt        = neg_r;
    mag_nxt        = mag_r;
    prod_nxt       = prod_r;
    res_nxt        = res_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_opac_nxt   = out_opac_r;
    out_last_nxt   = out_last_r;
    div_start      = 1'b0;
    in_tready      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          p_nxt    = in_tdata;
          last_nxt = in_tlast;
          if (in_tuser) begin
            state_nxt = ST_CHK_LO;
          end else begin
            res_nxt   = '0;
            state_nxt = ST_FIN;
          end
        end
      end
      ST_CHK_LO: begin
        if (cmp_lt || cmp_eq) begin
          res_nxt   = rd_opac;
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_CHK_HI;
        end
      end
      ST_CHK_HI: begin
        if (!cmp_lt) begin
          res_nxt   = rd_opac;
          state_nxt = ST_FIN;
        end else begin
          k_nxt     = IDX_W'(1);
          state_nxt = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (cmp_lt || k_r == last_idx) begin
          x1_nxt    = rd_pos;
          o1_nxt    = rd_opac;
          k_nxt     = k_r - 1'b1;
          state_nxt = ST_LOWER;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_LOWER: begin
        o0_nxt    = rd_opac;
        t_nxt     = cmp_diff[SPAN_W-1:0];
        span_nxt  = {x1_r[POS_W-1], x1_r} - {rd_pos[POS_W-1], rd_pos};
        neg_nxt   = d_opac[OPAC_W];
        mag_nxt   = d_opac[OPAC_W] ? OPAC_W'(-d_opac) : d_opac[OPAC_W-1:0];
        state_nxt = ST_MULT;
      end
      ST_MULT: begin
        prod_nxt = mag_r * t_r;
        if (span_pos) begin
          state_nxt = ST_DIVGO;
        end else begin
          res_nxt   = o0_r;
          state_nxt = ST_FIN;
        end
      end
      ST_DIVGO: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_sts.done) begin
          res_nxt   = neg_r ? (o0_r - quot) : (o0_r + quot);
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_opac_nxt   = res_r;
          out_last_nxt   = last_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      k_r          <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      k_r          <= k_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r        <= p_nxt;
    last_r     <= last_nxt;
    x1_r       <= x1_nxt;
    o1_r       <= o1_nxt;
    o0_r       <= o0_nxt;
    t_r        <= t_nxt;
    span_r     <= span_nxt;
    neg_r      <= neg_nxt;
    mag_r      <= mag_nxt;
    prod_r     <= prod_nxt;
    res_r      <= res_nxt;
    out_opac_r <= out_opac_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_opac_r;
  assign out_tlast  = out_last_r;

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> state_r == ST_DIV)
    else $error("divider result outside divide step");

  a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> (state_r == ST_CHK_LO || state_r == ST_FIN))
    else $error("unexpected step after input transaction");

  a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SRCH |-> (k_r != '0 && k_r <= last_idx))
    else $error("point walk index out of range");

endmodule

### test/piecewise_linear_opacity_map_unit_tb.sv
// testbench for the piecewise-linear opacity map unit
// loads control point sets over the cfg port, streams positions and checks each opacity
// depends on plom_pkg and piecewise_linear_opacity_map_unit
`timescale 1ns / 1ps

module piecewise_linear_opacity_map_unit_tb;
  import plom_pkg::*;

  localparam int MAX_PTS     = 7;
  localparam int NUM_PT_REGS = 7;
  localparam int PHASE_ITEMS = 50;
  localparam int RAND_PHASES = 16;
  localparam int LONG_HOLD   = 400;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [OPAC_W-1:0] opacity;
    logic              last;
  } opac_result_t;

  class opacity_scoreboard;
    logic [NUM_W-1:0] num_points;
    logic [PT_W-1:0]  points [NUM_PT_REGS];
    opac_result_t     expected_q [$];
    int               mismatches;

    function new();
      num_points = NUM_POINTS_RST;
      foreach (points[k]) points[k] = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [PT_W-1:0] data);
      if (idx == REG_NUM_POINTS) begin
        num_points = data[NUM_W-1:0];
      end else begin
        points[idx - REG_POINT_0] = data;
      end
    endfunction

    function longint point_pos(int k);
      return longint'($signed(points[k][PT_W-1:OPAC_W]));
    endfunction

    function longint point_opac(int k);
      return longint'(points[k][OPAC_W-1:0]);
    endfunction

    function logic [OPAC_W-1:0] map_position(longint p);
      int     n;
      int     top;
      int     j;
      longint x0;
      longint x1;
      longint o0;
      longint o1;
      longint span;
      n = (num_points == 0) ? 1 : int'(num_points);
      if (n > MAX_PTS) n = MAX_PTS;
      top = n - 1;
      if (p <= point_pos(0)) return OPAC_W'(point_opac(0));
      if (p >= point_pos(top)) return OPAC_W'(point_opac(top));
      j = 1;
      while (j < top && p >= point_pos(j)) j++;
      x0 = point_pos(j - 1);
      x1 = point_pos(j);
      o0 = point_opac(j - 1);
      o1 = point_opac(j);
      span = x1 - x0;
      if (span <= 0) return OPAC_W'(o0);
      // signed division truncates toward zero
      return OPAC_W'(o0 + (o1 - o0) * (p - x0) / span);
    endfunction

    function void note_position(logic [POS_W-1:0] pos, logic valid, logic last);
      opac_result_t r;
      r.opacity = valid ? map_position(longint'($signed(pos))) : '0;
      r.last    = last;
      expected_q.push_back(r);
    endfunction

    function void record_error(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%t %s", $realtime, msg);
    endfunction

    function void check_opacity(logic [OPAC_W-1:0] opac, logic last);
      opac_result_t r;
      if (expected_q.size() == 0) begin
        record_error($sformatf("result with none expected: opacity %0d last %0b", opac, last));
        return;
      end
      r = expected_q.pop_front();
      if (r.opacity !== opac || r.last !== last) begin
        record_error($sformatf("mismatch: expected opacity %0d last %0b, got opacity %0d last %0b",
                               r.opacity, r.last, opac, last));
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [POS_W-1:0]     in_tdata;   // [31:0] position
  logic                 in_tuser;   // [0] position_valid
  logic                 in_tlast;   // last_entry
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OPAC_W-1:0]    out_tdata;  // [15:0] opacity
  logic                 out_tlast;  // last_out
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PT_W-1:0]      cfg_wdata;

  opacity_scoreboard sb = new();

  int                tx_gap_pct = 0;
  int                rx_stall_pct = 0;
  int                rx_wait = 0;
  int                hold_reqs = 0;
  int                hold_seen = 0;
  int                curve_pos [NUM_PT_REGS];
  logic [OPAC_W-1:0] curve_opac [NUM_PT_REGS];

  piecewise_linear_opacity_map_unit #(
    .MAX_POINTS(MAX_PTS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap(int pct);
    if ($urandom_range(99) >= pct) return 0;
    return ($urandom_range(9) < 8) ? int'($urandom_range(1, 3)) : int'($urandom_range(10, 60));
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.write_reg(cfg_index, cfg_wdata);
      if (in_tvalid && in_tready) sb.note_position(in_tdata, in_tuser, in_tlast);
      if (out_tvalid && out_tready) sb.check_opacity(out_tdata, out_tlast);
    end
  end

  always @(posedge clk) begin : rx_pacing
    int gap;
    if (hold_seen != hold_reqs) begin
      hold_seen  <= hold_reqs;
      rx_wait    <= LONG_HOLD;
      out_tready <= 1'b0;
    end else if (rx_wait != 0) begin
      rx_wait    <= rx_wait - 1;
      out_tready <= 1'b0;
    end else begin
      gap = pick_gap(rx_stall_pct);
      if (gap != 0) begin
        rx_wait    <= gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_position(input logic [POS_W-1:0] pos, input logic valid, input logic last);
    int gap;
    gap = pick_gap(tx_gap_pct);
    in_tvalid <= 1'b1;
    in_tdata  <= pos;
    in_tuser  <= valid;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_opacities();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic load_curve(input int num);
    for (int k = 0; k <= NUM_PT_REGS; k++) begin
      cfg_we <= 1'b1;
      if (k == 0) begin
        cfg_index <= REG_NUM_POINTS;
        cfg_wdata <= PT_W'(num);
      end else begin
        cfg_index <= REG_POINT_0 + CFG_IDX_W'(k - 1);
        cfg_wdata <= {curve_pos[k - 1], curve_opac[k - 1]};
      end
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_curve();
    int vals [$];
    int base;
    int mode;
    int r;
    mode = $urandom_range(3);
    base = $signed($urandom()) >>> 2;
    for (int k = 0; k < NUM_PT_REGS; k++) begin
      case (mode)
        0, 2:    vals.push_back(int'($urandom()));
        1:       vals.push_back(base + int'($urandom_range(4095)));
        default: vals.push_back(base + 1000 * int'($urandom_range(2)));
      endcase
    end
    // mode 2 leaves the points out of order
    if (mode != 2) vals.sort();
    for (int k = 0; k < NUM_PT_REGS; k++) begin
      r = $urandom_range(99);
      curve_pos[k]  = vals[k];
      curve_opac[k] = (r < 15) ? '0 : (r < 30) ? '1 : OPAC_W'($urandom());
    end
  endtask

  function automatic logic [POS_W-1:0] pick_position(int n);
    int     r;
    int     k;
    longint lo;
    longint hi;
    longint t;
    r = $urandom_range(99);
    if (r < 55 && n >= 2) begin
      k  = $urandom_range(n - 2);
      lo = curve_pos[k];
      hi = curve_pos[k + 1];
      if (hi < lo) begin
        t  = lo;
        lo = hi;
        hi = t;
      end
      return POS_W'(lo + longint'($urandom()) % (hi - lo + 1));
    end else if (r < 70) begin
      return POS_W'(curve_pos[$urandom_range(n - 1)] + int'($urandom_range(2)) - 1);
    end else if (r < 90) begin
      return $urandom();
    end
    case ($urandom_range(3))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  initial begin : stimulus
    int num;
    int pcts [3];
    pcts = '{0, 15, 40};
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    in_tlast  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers at their reset values
    tx_gap_pct   = 20;
    rx_stall_pct = 20;
    send_position('0, 1'b1, 1'b0);
    send_position(32'h7FFF_FFFF, 1'b1, 1'b1);
    send_position(32'h8000_0000, 1'b0, 1'b0);
    drain_opacities();

    // seven ascending points spanning the whole position range
    curve_pos  = '{32'sh8000_0000, -1000000, -65536, 0, 65536, 1000000, 32'sh7FFF_FFFF};
    curve_opac = '{16'hFFFF, 16'd0, 16'd40000, 16'd12345, 16'hFFFF, 16'd1, 16'd0};
    load_curve(MAX_PTS);
    send_position(32'h8000_0000, 1'b1, 1'b0);
    send_position(32'h7FFF_FFFF, 1'b1, 1'b0);
    send_position(-65536, 1'b1, 1'b0);
    send_position(-500000, 1'b1, 1'b0);
    send_position(-1, 1'b1, 1'b1);
    send_position(32768, 1'b1, 1'b0);
    send_position(2000000, 1'b1, 1'b0);
    send_position(-2000000, 1'b1, 1'b0);
    send_position(12345, 1'b0, 1'b1);
    send_position(32'h7FFF_FFFF, 1'b0, 1'b0);
    drain_opacities();

    // point count of zero acts as a single point
    curve_pos  = '{65536, -5, 7, 0, 0, 0, 0};
    curve_opac = '{16'd777, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6};
    load_curve(0);
    send_position('0, 1'b1, 1'b0);
    send_position(200000, 1'b1, 1'b1);
    send_position(65536, 1'b0, 1'b0);
    drain_opacities();

    // points out of order
    curve_pos  = '{0, 100, 50, 200, -10, 300, 250};
    curve_opac = '{16'd0, 16'd1000, 16'd60000, 16'hFFFF, 16'd5, 16'd30000, 16'd100};
    load_curve(MAX_PTS);
    send_position(75, 1'b1, 1'b0);
    send_position(150, 1'b1, 1'b0);
    send_position(260, 1'b1, 1'b1);
    send_position(299, 1'b1, 1'b0);
    send_position(60, 1'b1, 1'b0);
    send_position(200, 1'b1, 1'b0);
    drain_opacities();

    // all register bits set
    curve_pos  = '{-1, -1, -1, -1, -1, -1, -1};
    curve_opac = '{'1, '1, '1, '1, '1, '1, '1};
    load_curve(MAX_PTS);
    send_position('1, 1'b1, 1'b0);
    send_position('0, 1'b1, 1'b1);
    send_position(-2, 1'b1, 1'b0);
    drain_opacities();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      num = (ph == 0) ? 1 : (ph == 1) ? MAX_PTS : int'($urandom_range(1, MAX_PTS));
      random_curve();
      load_curve(num);
      tx_gap_pct   = pcts[$urandom_range(2)];
      rx_stall_pct = pcts[$urandom_range(2)];
      if (ph == 2) begin
        // receiver stalls while the sender keeps offering back to back
        hold_reqs  <= hold_reqs + 1;
        tx_gap_pct = 0;
      end
      if (ph == 3) begin
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_position(pick_position(num), $urandom_range(9) != 0, $urandom_range(7) == 0);
      end
      drain_opacities();
    end

    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("piecewise_linear_opacity_map_unit test passed");
    end else begin
      $display("piecewise_linear_opacity_map_unit test failed");
    end
    $finish;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("piecewise_linear_opacity_map_unit test failed");
    $finish;
  end

endmodule

### filelist.f
rtl/plom_pkg.sv
rtl/plom_cfg_regs.sv
rtl/plom_div.sv
rtl/piecewise_linear_opacity_map_unit.sv
test/piecewise_linear_opacity_map_unit_tb.sv
